// ===== src/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define CHK_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== src/ifd_pkg.sv =====
// Package: frame constants, CRC byte update and inter-module structs for the deframer.
`timescale 1ns / 1ps

package ifd_pkg;

  localparam logic [7:0]  HDR0_BYTE = 8'h55;
  localparam logic [7:0]  HDR1_BYTE = 8'hAA;
  localparam logic [7:0]  TAIL_BYTE = 8'h0A;
  localparam logic [7:0]  REG_GYRO  = 8'h02;
  localparam logic [7:0]  REG_EULER = 8'h03;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // byte positions within a frame
  localparam logic [4:0] POS_HDR1     = 5'd1;
  localparam logic [4:0] POS_ID       = 5'd2;
  localparam logic [4:0] POS_REG      = 5'd3;
  localparam logic [4:0] POS_VALUE    = 5'd12;
  localparam logic [4:0] POS_CRC_LO   = 5'd16;
  localparam logic [4:0] POS_CRC_HI   = 5'd17;
  localparam logic [4:0] POS_TAIL     = 5'd18;

  localparam logic KIND_GYRO_Z = 1'b0;
  localparam logic KIND_YAW    = 1'b1;

  typedef struct packed {
    logic at_tail;   // next word closes a frame and may produce a result
  } parser_status_t;

  typedef struct packed {
    logic        emit;
    logic        updated_kind;
    logic [31:0] yaw_bits;
    logic [31:0] gyro_z_bits;
  } parser_result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/ifd_byte_if.sv =====
// Byte stream channel: valid/ready handshake carrying one received byte.
`timescale 1ns / 1ps

interface ifd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/ifd_result_if.sv =====
// Result channel: valid/ready handshake carrying the updated IMU values.
`timescale 1ns / 1ps

interface ifd_result_if;
  logic        valid;
  logic        ready;
  logic        updated_kind;
  logic [31:0] yaw_bits;
  logic [31:0] gyro_z_bits;

  modport source (output valid, output updated_kind, output yaw_bits, output gyro_z_bits,
                  input ready);
  modport sink   (input valid, input updated_kind, input yaw_bits, input gyro_z_bits,
                  output ready);
endinterface

// ===== src/ifd_frame_parser.sv =====
// Frame parser: header hunt, running CRC, field capture and value stores.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ifd_frame_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             node_id,
  output ifd_pkg::parser_status_t status,
  output ifd_pkg::parser_result_t result
);

  logic [4:0]  fill_count, fill_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic        id_matches, id_matches_next;
  logic [7:0]  register_code, register_code_next;
  logic [31:0] value_word, value_word_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic        crc_matches, crc_matches_next;
  logic [31:0] yaw_store, yaw_store_next;
  logic [31:0] gyro_z_store, gyro_z_store_next;
  logic        emit;
  logic        kind;

  always_comb begin
    fill_count_next    = fill_count;
    running_crc_next   = running_crc;
    id_matches_next    = id_matches;
    register_code_next = register_code;
    value_word_next    = value_word;
    crc_low_byte_next  = crc_low_byte;
    crc_matches_next   = crc_matches;
    yaw_store_next     = yaw_store;
    gyro_z_store_next  = gyro_z_store;
    emit               = 1'b0;
    kind               = ifd_pkg::KIND_GYRO_Z;

    if (accept) begin
      if (fill_count == 5'd0) begin
        if (rx_byte == ifd_pkg::HDR0_BYTE) begin
          running_crc_next = ifd_pkg::crc16_feed(ifd_pkg::CRC_INIT, rx_byte);
          fill_count_next  = ifd_pkg::POS_HDR1;
        end
      end else if (fill_count == ifd_pkg::POS_HDR1) begin
        // a bad second byte is dropped along with the 0x55
        if (rx_byte != ifd_pkg::HDR1_BYTE) begin
          fill_count_next = 5'd0;
        end else begin
          running_crc_next = ifd_pkg::crc16_feed(running_crc, rx_byte);
          fill_count_next  = ifd_pkg::POS_ID;
        end
      end else if (fill_count < ifd_pkg::POS_CRC_LO) begin
        running_crc_next = ifd_pkg::crc16_feed(running_crc, rx_byte);
        if (fill_count == ifd_pkg::POS_ID) begin
          id_matches_next = (rx_byte == node_id);
        end else if (fill_count == ifd_pkg::POS_REG) begin
          register_code_next = rx_byte;
        end else if (fill_count >= ifd_pkg::POS_VALUE) begin
          value_word_next = {rx_byte, value_word[31:8]};  // little-endian
        end
        fill_count_next = fill_count + 5'd1;
      end else if (fill_count == ifd_pkg::POS_CRC_LO) begin
        crc_low_byte_next = rx_byte;
        fill_count_next   = fill_count + 5'd1;
      end else if (fill_count == ifd_pkg::POS_CRC_HI) begin
        crc_matches_next = (running_crc == {rx_byte, crc_low_byte});
        fill_count_next  = fill_count + 5'd1;
      end else begin
        // tail position, or any out-of-range count
        fill_count_next = 5'd0;
        if (rx_byte == ifd_pkg::TAIL_BYTE && id_matches && crc_matches) begin
          if (register_code == ifd_pkg::REG_GYRO) begin
            gyro_z_store_next = value_word;
            emit              = 1'b1;
            kind              = ifd_pkg::KIND_GYRO_Z;
          end else if (register_code == ifd_pkg::REG_EULER) begin
            yaw_store_next = value_word;
            emit           = 1'b1;
            kind           = ifd_pkg::KIND_YAW;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= 5'd0;
      running_crc   <= ifd_pkg::CRC_INIT;
      id_matches    <= 1'b0;
      register_code <= 8'd0;
      value_word    <= 32'd0;
      crc_low_byte  <= 8'd0;
      crc_matches   <= 1'b0;
      yaw_store     <= 32'd0;
      gyro_z_store  <= 32'd0;
    end else begin
      fill_count    <= fill_count_next;
      running_crc   <= running_crc_next;
      id_matches    <= id_matches_next;
      register_code <= register_code_next;
      value_word    <= value_word_next;
      crc_low_byte  <= crc_low_byte_next;
      crc_matches   <= crc_matches_next;
      yaw_store     <= yaw_store_next;
      gyro_z_store  <= gyro_z_store_next;
    end
  end

  assign status.at_tail       = (fill_count >= ifd_pkg::POS_TAIL);
  assign result.emit          = emit;
  assign result.updated_kind  = kind;
  assign result.yaw_bits      = yaw_store_next;
  assign result.gyro_z_bits   = gyro_z_store_next;

  `CHK_RUN(a_tail_restarts, clk, rst,
    accept && status.at_tail |=> fill_count == 5'd0,
    "frame did not restart after tail word")
  `CHK_RUN(a_hdr_stall_holds, clk, rst,
    !accept && fill_count == 5'd0 |=> fill_count == 5'd0,
    "header hunt advanced without a word")
  `CHK_ALWAYS(a_emit_needs_accept, clk,
    result.emit |-> accept,
    "result produced without a word")

endmodule

// ===== src/imu_frame_deframer_crc16.sv =====
// A result is registered and appears on the output in the cycle after its tail word is accepted.
// Throughput: one byte per cycle while in_ch.ready is high; the byte path is a single registered step
// (CRC byte update and framing compare) between the input handshake and state.
// A pending result stalls input only when the next word is a tail word.
// Reset (rst, synchronous, active high) starts the header hunt, CRC at 0xFFFF,
// clears the stored values, the node id and the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imu_frame_deframer_crc16 (
  input  logic                clk,
  input  logic                rst,
  ifd_byte_if.sink            in_ch,
  ifd_result_if.source        out_ch,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  logic [7:0]               node_id;
  ifd_pkg::parser_status_t  status;
  ifd_pkg::parser_result_t  result;
  logic                     in_acc;
  logic                     out_valid;
  logic                     out_kind;
  logic [31:0]              out_yaw;
  logic [31:0]              out_gyro;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= 8'd0;
    end else if (cfg_wr_en) begin
      node_id <= cfg_wr_data;
    end
  end

  // only a tail word can produce a result, so hold off just that one
  assign in_ch.ready = !(status.at_tail && out_valid && !out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  ifd_frame_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_acc),
    .rx_byte   (in_ch.rx_byte),
    .node_id   (node_id),
    .status    (status),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.emit) begin
      out_kind <= result.updated_kind;
      out_yaw  <= result.yaw_bits;
      out_gyro <= result.gyro_z_bits;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.updated_kind = out_kind;
  assign out_ch.yaw_bits     = out_yaw;
  assign out_ch.gyro_z_bits  = out_gyro;

  `CHK_RUN(a_emit_at_tail, clk, rst,
    result.emit |-> status.at_tail,
    "result from a word that is not a tail")
  `CHK_RUN(a_no_overwrite, clk, rst,
    result.emit |-> !out_valid || out_ch.ready,
    "pending result overwritten")
  `CHK_RUN(a_emit_shows, clk, rst,
    result.emit |=> out_valid,
    "result not presented after emit")

endmodule
